// ----- rtl/tdsm_pkg.sv -----
// Shared types and constants for the two-wire display serial master.
// Used by tdsm_front, tdsm_back and the top level; no dependencies.
package tdsm_pkg;

   // Item kinds; a running command keeps the same codes, with zero as idle
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_SEND  = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;
   localparam logic [1:0] CMD_IDLE   = 2'd0;

   localparam int unsigned LINES      = 3;
   localparam int unsigned QUEUE_AW   = 2;
   localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

   // Action indexes within a send sequence
   localparam logic [4:0] SEND_BIT_ACTIONS = 5'd24;
   localparam logic [4:0] SEND_CLK_LO      = 5'd24;
   localparam logic [4:0] SEND_RELEASE     = 5'd25;
   localparam logic [4:0] SEND_CLK_HI      = 5'd26;
   localparam logic [4:0] SEND_SAMPLE      = 5'd27;
   localparam logic [1:0] SUB_LAST         = 2'd2;

   typedef enum logic [2:0] {
      ACT_CLK_LO,
      ACT_CLK_HI,
      ACT_DATA_HI,
      ACT_DATA_LO,
      ACT_DATA_BIT,
      ACT_RELEASE,
      ACT_SAMPLE,
      ACT_DRIVE
   } action_type;

   // One classified entry of the queue between front and back
   typedef struct packed {
      logic       is_tick;
      logic [1:0] kind;
      logic [1:0] line;
      logic [7:0] data_byte;
      logic       data_in;
   } item_type;

   function automatic logic [LINES-1:0] line_mask(input logic [1:0] line);
      logic [LINES-1:0] m;
      case (line)
         2'd0:    m = 3'b001;
         2'd1:    m = 3'b010;
         2'd2:    m = 3'b100;
         default: m = 3'b000;
      endcase
      return m;
   endfunction

endpackage

// ----- rtl/two_wire_display_serial_master_unit.sv -----
// Two-wire display serial master: shared clock line plus three data lines.
// Each request beat is a phase tick (kind 0) or a command: start, send byte
// (LSB first, then acknowledge sample) or stop. A command performs its first
// pin action at once; each later tick performs the next one.
// Every request beat yields exactly one response beat carrying the pin
// levels, release mask, busy, done pulse, acknowledge and reject flags as
// they stand after that beat. A command while busy is rejected unchanged.
// With the queue empty, an accepted request passes through the queue and then
// the back-end register before rsp_valid rises.
// Throughput: one beat per cycle unless the receiver stalls, set by the back
// end, which executes one queue entry per cycle into its output register.
// When the receiver stalls, the output register holds its beat, the back end
// waits, and the queue fills; req_stall rises once its four entries are full.
// Reset (synchronous, active high) empties the queue, drops the pending
// response, and leaves clock and data lines high, all driven, idle.
// Depends on tdsm_pkg, tdsm_front and tdsm_back.
module two_wire_display_serial_master_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [1:0] req_line_select,
   input  logic [7:0] req_data_byte,
   input  logic       req_data_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_clock_level,
   output logic [2:0] rsp_data_levels,
   output logic [2:0] rsp_data_released,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_acknowledged,
   output logic       rsp_rejected
);
   import tdsm_pkg::*;

   logic     head_valid;
   logic     head_take;
   item_type head_item;

   tdsm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_line_select (req_line_select),
      .req_data_byte   (req_data_byte),
      .req_data_in     (req_data_in),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_take       (head_take)
   );

   tdsm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .head_take         (head_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_clock_level   (rsp_clock_level),
      .rsp_data_levels   (rsp_data_levels),
      .rsp_data_released (rsp_data_released),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_acknowledged  (rsp_acknowledged),
      .rsp_rejected      (rsp_rejected)
   );

endmodule

// ----- rtl/tdsm_front.sv -----
// Front end: classifies request beats and holds them in a short queue.
// Depends on tdsm_pkg.
module tdsm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [1:0]            req_line_select,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_data_in,
   output logic                  head_valid,
   output tdsm_pkg::item_type    head_item,
   input  logic                  head_take
);
   import tdsm_pkg::*;

   item_type               queue_mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   push;
   item_type               new_item;

   assign req_stall = (count_ff == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      new_item.is_tick   = (req_kind == KIND_TICK);
      new_item.kind      = req_kind;
      new_item.line      = req_line_select;
      new_item.data_byte = req_data_byte;
      new_item.data_in   = req_data_in;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = head_take ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(head_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = queue_mem[rd_ptr_ff];

endmodule

// ----- rtl/tdsm_back.sv -----
// Back end: runs pin sequences for start, send byte and stop, one queue entry per
// cycle unless stalled; its output register holds the result beat. Uses tdsm_pkg.
module tdsm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  tdsm_pkg::item_type    head_item,
   output logic                  head_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clock_level,
   output logic [2:0]            rsp_data_levels,
   output logic [2:0]            rsp_data_released,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_acknowledged,
   output logic                  rsp_rejected
);
   import tdsm_pkg::*;

   logic [4:0]       phase_ff, phase_in;
   logic [1:0]       sub_ff, sub_in;
   logic [2:0]       bit_ff, bit_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [7:0]       shift_ff, shift_in;
   logic [1:0]       line_ff, line_in;
   logic             clk_ff, clk_in;
   logic [LINES-1:0] data_ff, data_in;
   logic [LINES-1:0] rel_ff, rel_in;
   logic             ack_ff, ack_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             done_ff, done_in;
   logic             rej_ff, rej_in;

   logic             run;
   logic [1:0]       act_cmd;
   logic [4:0]       act_idx;
   logic [1:0]       act_sub;
   logic             act_last;
   action_type       act;
   logic [LINES-1:0] mask;

   assign head_take = head_valid && (!rsp_valid_ff || !rsp_stall);

   // Map a command and action index to the pin action
   always_comb begin
      act      = ACT_DRIVE;
      act_last = 1'b0;
      case (act_cmd)
         KIND_START: begin
            if (act_idx == 5'd0) act = ACT_DATA_HI;
            else if (act_idx == 5'd1) act = ACT_CLK_HI;
            else begin
               act      = ACT_DATA_LO;
               act_last = 1'b1;
            end
         end
         KIND_STOP: begin
            if (act_idx == 5'd0) act = ACT_CLK_LO;
            else if (act_idx == 5'd1) act = ACT_DATA_LO;
            else if (act_idx == 5'd2) act = ACT_CLK_HI;
            else begin
               act      = ACT_DATA_HI;
               act_last = 1'b1;
            end
         end
         KIND_SEND: begin
            if (act_idx < SEND_BIT_ACTIONS) begin
               if (act_sub == 2'd0) act = ACT_CLK_LO;
               else if (act_sub == 2'd1) act = ACT_DATA_BIT;
               else act = ACT_CLK_HI;
            end else if (act_idx == SEND_CLK_LO) act = ACT_CLK_LO;
            else if (act_idx == SEND_RELEASE) act = ACT_RELEASE;
            else if (act_idx == SEND_CLK_HI) act = ACT_CLK_HI;
            else if (act_idx == SEND_SAMPLE) act = ACT_SAMPLE;
            else begin
               act      = ACT_DRIVE;
               act_last = 1'b1;
            end
         end
         default: begin
            act      = ACT_DRIVE;
            act_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      sub_in   = sub_ff;
      bit_in   = bit_ff;
      cmd_in   = cmd_ff;
      shift_in = shift_ff;
      line_in  = line_ff;
      clk_in   = clk_ff;
      data_in  = data_ff;
      rel_in   = rel_ff;
      ack_in   = ack_ff;
      done_in  = 1'b0;
      rej_in   = 1'b0;
      run      = 1'b0;
      act_cmd  = cmd_ff;
      act_idx  = phase_ff + 5'd1;
      act_sub  = (sub_ff == SUB_LAST) ? 2'd0 : sub_ff + 2'd1;

      if (head_item.is_tick) begin
         if (cmd_ff != CMD_IDLE) begin
            run      = 1'b1;
            phase_in = act_idx;
            sub_in   = act_sub;
            bit_in   = (sub_ff == SUB_LAST) ? bit_ff + 3'd1 : bit_ff;
         end
      end else if (cmd_ff != CMD_IDLE) begin
         rej_in = 1'b1;
      end else begin
         run      = 1'b1;
         act_cmd  = head_item.kind;
         act_idx  = 5'd0;
         act_sub  = 2'd0;
         cmd_in   = head_item.kind;
         line_in  = head_item.line;
         shift_in = head_item.data_byte;
         phase_in = 5'd0;
         sub_in   = 2'd0;
         bit_in   = 3'd0;
      end

      mask = line_mask(line_in);

      if (run) begin
         case (act)
            ACT_CLK_LO:   clk_in = 1'b0;
            ACT_CLK_HI:   clk_in = 1'b1;
            ACT_DATA_HI:  data_in = data_ff | mask;
            ACT_DATA_LO:  data_in = data_ff & ~mask;
            ACT_DATA_BIT: data_in = shift_in[bit_in] ? (data_ff | mask) : (data_ff & ~mask);
            ACT_RELEASE: begin
               data_in = data_ff | mask;
               rel_in  = rel_ff | mask;
            end
            ACT_SAMPLE: begin
               ack_in = !head_item.data_in;
               clk_in = 1'b0;
            end
            ACT_DRIVE:    rel_in = rel_ff & ~mask;
            default:      clk_in = clk_ff;
         endcase
         if (act_last) begin
            done_in  = 1'b1;
            cmd_in   = CMD_IDLE;
            phase_in = 5'd0;
         end
      end

      rsp_valid_in = head_take || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         sub_ff       <= '0;
         bit_ff       <= '0;
         cmd_ff       <= CMD_IDLE;
         shift_ff     <= '0;
         line_ff      <= '0;
         clk_ff       <= 1'b1;
         data_ff      <= '1;
         rel_ff       <= '0;
         ack_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (head_take) begin
            phase_ff <= phase_in;
            sub_ff   <= sub_in;
            bit_ff   <= bit_in;
            cmd_ff   <= cmd_in;
            shift_ff <= shift_in;
            line_ff  <= line_in;
            clk_ff   <= clk_in;
            data_ff  <= data_in;
            rel_ff   <= rel_in;
            ack_ff   <= ack_in;
         end
      end
   end

   // Pulse flags of the held result beat
   always_ff @(posedge clock) begin
      if (head_take) begin
         done_ff <= done_in;
         rej_ff  <= rej_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clock_level   = clk_ff;
   assign rsp_data_levels   = data_ff;
   assign rsp_data_released = rel_ff;
   assign rsp_busy_res      = (cmd_ff != CMD_IDLE);
   assign rsp_done_res      = done_ff;
   assign rsp_acknowledged  = ack_ff;
   assign rsp_rejected      = rej_ff;

endmodule

// ----- sim/two_wire_display_serial_master_unit_tb.sv -----
// Self-checking testbench for the two-wire display serial master: drives command and tick beats,
// predicts every response beat with a scoreboard class and compares field by field.
// Depends on tdsm_pkg and two_wire_display_serial_master_unit.
module two_wire_display_serial_master_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdsm_pkg::*;

   typedef struct packed {
      logic       clock_level;
      logic [2:0] data_levels;
      logic [2:0] data_released;
      logic       busy;
      logic       done;
      logic       acknowledged;
      logic       rejected;
   } pin_state_type;

   class pin_scoreboard;
      logic [4:0] phase;
      logic [1:0] cmd;
      logic [1:0] line;
      logic [7:0] shift;
      logic       clk_lvl;
      logic [2:0] data_lvl;
      logic [2:0] rel;
      logic       ack;
      pin_state_type pending_q[$];
      int unsigned errors;
      int unsigned reports;

      function new();
         phase = '0;
         cmd = CMD_IDLE;
         line = '0;
         shift = '0;
         clk_lvl = 1'b1;
         data_lvl = 3'b111;
         rel = 3'b000;
         ack = 1'b0;
         errors = 0;
         reports = 0;
      endfunction

      function bit busy();
         return cmd != CMD_IDLE;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      // Perform pin action idx of the running command; return 1 on its last action.
      function bit drive_action(input logic [4:0] idx, input logic din);
         logic [2:0] m;
         int bitpos;
         int sub;
         m = (line == 2'd3) ? 3'b000 : (3'b001 << line);
         bitpos = idx / 3;
         sub = idx % 3;
         case (cmd)
            KIND_START: begin
               if (idx == 0) data_lvl |= m;
               else if (idx == 1) clk_lvl = 1'b1;
               else begin
                  data_lvl &= ~m;
                  return 1'b1;
               end
            end
            KIND_STOP: begin
               if (idx == 0) clk_lvl = 1'b0;
               else if (idx == 1) data_lvl &= ~m;
               else if (idx == 2) clk_lvl = 1'b1;
               else begin
                  data_lvl |= m;
                  return 1'b1;
               end
            end
            KIND_SEND: begin
               if (idx < SEND_BIT_ACTIONS) begin
                  if (sub == 0) clk_lvl = 1'b0;
                  else if (sub == SUB_LAST) clk_lvl = 1'b1;
                  else if (shift[bitpos]) data_lvl |= m;
                  else data_lvl &= ~m;
               end else if (idx == SEND_CLK_LO) begin
                  clk_lvl = 1'b0;
               end else if (idx == SEND_RELEASE) begin
                  data_lvl |= m;
                  rel |= m;
               end else if (idx == SEND_CLK_HI) begin
                  clk_lvl = 1'b1;
               end else if (idx == SEND_SAMPLE) begin
                  ack = ~din;
                  clk_lvl = 1'b0;
               end else begin
                  rel &= ~m;
                  return 1'b1;
               end
            end
            default: return 1'b1;
         endcase
         return 1'b0;
      endfunction

      function void note_request(input logic [1:0] kind, input logic [1:0] sel,
                                 input logic [7:0] value, input logic din);
         pin_state_type s;
         logic done;
         logic rej;
         done = 1'b0;
         rej = 1'b0;
         if (kind == KIND_TICK) begin
            if (cmd != CMD_IDLE) begin
               phase = phase + 5'd1;
               if (drive_action(phase, din)) begin
                  done = 1'b1;
                  cmd = CMD_IDLE;
                  phase = '0;
               end
            end
         end else if (cmd != CMD_IDLE) begin
            // command while busy: drop it, state unchanged
            rej = 1'b1;
         end else begin
            cmd = kind;
            line = sel;
            shift = value;
            phase = '0;
            if (drive_action(phase, din)) begin
               done = 1'b1;
               cmd = CMD_IDLE;
            end
         end
         s.clock_level = clk_lvl;
         s.data_levels = data_lvl;
         s.data_released = rel;
         s.busy = (cmd != CMD_IDLE);
         s.done = done;
         s.acknowledged = ack;
         s.rejected = rej;
         pending_q.push_back(s);
      endfunction

      function void report(input string what, input int exp_v, input int act_v);
         errors++;
         if (reports < 40) begin
            reports++;
            $display("%0t: %s expected %0h, actual %0h", $time, what, exp_v, act_v);
         end
      endfunction

      function void check_response(input pin_state_type got);
         pin_state_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (reports < 40) begin
               reports++;
               $display("%0t: response beat with none expected, actual %h", $time, got);
            end
            return;
         end
         want = pending_q.pop_front();
         if (want.clock_level != got.clock_level)
            report("clock_level", want.clock_level, got.clock_level);
         if (want.data_levels != got.data_levels)
            report("data_levels", want.data_levels, got.data_levels);
         if (want.data_released != got.data_released)
            report("data_released", want.data_released, got.data_released);
         if (want.busy != got.busy)
            report("busy_res", want.busy, got.busy);
         if (want.done != got.done)
            report("done_res", want.done, got.done);
         if (want.acknowledged != got.acknowledged)
            report("acknowledged", want.acknowledged, got.acknowledged);
         if (want.rejected != got.rejected)
            report("rejected", want.rejected, got.rejected);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_kind;
   logic [1:0] req_line_select;
   logic [7:0] req_data_byte;
   logic       req_data_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_clock_level;
   logic [2:0] rsp_data_levels;
   logic [2:0] rsp_data_released;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic       rsp_acknowledged;
   logic       rsp_rejected;

   pin_scoreboard sb;
   int  beats_sent;
   int  hold_request;
   bit  eager;

   two_wire_display_serial_master_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_line_select   (req_line_select),
      .req_data_byte     (req_data_byte),
      .req_data_in       (req_data_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_clock_level   (rsp_clock_level),
      .rsp_data_levels   (rsp_data_levels),
      .rsp_data_released (rsp_data_released),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_acknowledged  (rsp_acknowledged),
      .rsp_rejected      (rsp_rejected)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [1:0] pick_line();
      if ($urandom_range(0, 7) == 0) return 2'd3;
      return 2'($urandom_range(0, 2));
   endfunction

   function automatic logic [7:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one beat after a random gap, or none when eager, and hold it until accepted.
   task automatic put_request(input logic [1:0] kind, input logic [1:0] sel,
                              input logic [7:0] value, input logic din);
      int gap;
      gap = eager ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_line_select <= sel;
      req_data_byte <= value;
      req_data_in <= din;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, sel, value, din);
   endtask

   // One command followed by ticks until it finishes, with a stray command now and then.
   task automatic run_command(input logic [1:0] kind);
      put_request(kind, pick_line(), pick_value(), 1'($urandom_range(0, 1)));
      beats_sent++;
      while (sb.busy()) begin
         if ($urandom_range(0, 15) == 0)
            put_request(2'($urandom_range(1, 3)), pick_line(), pick_value(),
                        1'($urandom_range(0, 1)));
         else
            put_request(KIND_TICK, pick_line(), pick_value(), 1'($urandom_range(0, 1)));
         beats_sent++;
      end
   endtask

   // Response side: check each accepted beat, then stall at random or for a long hold-off.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         pin_state_type got;
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.clock_level = rsp_clock_level;
            got.data_levels = rsp_data_levels;
            got.data_released = rsp_data_released;
            got.busy = rsp_busy_res;
            got.done = rsp_done_res;
            got.acknowledged = rsp_acknowledged;
            got.rejected = rsp_rejected;
            sb.check_response(got);
            stall_left = eager ? 0 : $urandom_range(0, 3);
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [1:0] kind;
      bit held;
      bit paused;
      int r;
      sb = new();
      beats_sent = 0;
      hold_request = 0;
      eager = 1'b0;
      held = 1'b0;
      paused = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= KIND_TICK;
      req_line_select <= 2'd0;
      req_data_byte <= 8'h00;
      req_data_in <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // tick while idle, then start / stop on edge lines with commands while busy
      put_request(KIND_TICK, 2'd2, 8'hFF, 1'b1);
      put_request(KIND_START, 2'd0, 8'h00, 1'b0);
      put_request(KIND_SEND, 2'd1, 8'hFF, 1'b1);
      repeat (2) put_request(KIND_TICK, 2'd3, 8'h00, 1'b0);
      put_request(KIND_STOP, 2'd3, 8'hAA, 1'b1);
      put_request(KIND_START, 2'd1, 8'h55, 1'b0);
      put_request(KIND_STOP, 2'd2, 8'h00, 1'b1);
      repeat (3) put_request(KIND_TICK, 2'd0, 8'hFF, 1'b1);
      put_request(KIND_START, 2'd2, 8'h80, 1'b1);
      repeat (2) put_request(KIND_TICK, 2'd1, 8'h01, 1'b0);
      put_request(KIND_STOP, 2'd1, 8'h7F, 1'b0);
      repeat (3) put_request(KIND_TICK, 2'd2, 8'h00, 1'b1);
      put_request(KIND_TICK, 2'd0, 8'h00, 1'b0);

      while (beats_sent < 1600) begin
         if (beats_sent >= 400 && !held) begin
            // receiver holds off while the sender keeps offering beats
            held = 1'b1;
            hold_request = 90;
         end
         if (beats_sent >= 900 && !paused) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 15) == 0) eager = !eager;
         r = $urandom_range(0, 9);
         if (r == 0) begin
            put_request(KIND_TICK, pick_line(), pick_value(), 1'($urandom_range(0, 1)));
            beats_sent++;
         end else begin
            kind = (r <= 2) ? KIND_START : ((r <= 4) ? KIND_STOP : KIND_SEND);
            run_command(kind);
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tdsm_pkg.sv
rtl/tdsm_front.sv
rtl/tdsm_back.sv
rtl/two_wire_display_serial_master_unit.sv
sim/two_wire_display_serial_master_unit_tb.sv
